### rtl/chs_pkg.sv
// Shared types and constants of the CHS/LBA address translator.
package chs_pkg;

   localparam int BLOCK_WIDTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CSR_HEADS   = 8'd0;
   localparam logic [7:0] CSR_SECTORS = 8'd1;

   localparam logic [7:0] HEADS_RESET   = 8'd16;
   localparam logic [7:0] SECTORS_RESET = 8'd63;

   localparam logic [7:0] FIXED_HEAD_LIMIT   = 8'd16;
   localparam logic [8:0] FIXED_SECTOR_LIMIT = 9'd63;

   localparam logic CMD_CHS_TO_LBA = 1'b0;
   localparam logic CMD_LBA_TO_CHS = 1'b1;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_ZERO_HEADS   = 3'd1;
   localparam logic [2:0] STATUS_ZERO_SECTORS = 3'd2;
   localparam logic [2:0] STATUS_ZERO_SECTOR  = 3'd3;
   localparam logic [2:0] STATUS_HEAD_BIG     = 3'd4;
   localparam logic [2:0] STATUS_SECTOR_BIG   = 3'd5;

   typedef struct packed {
      logic [7:0] heads;
      logic [7:0] sectors;
   } chs_geom_type;

endpackage

### rtl/chs_lba_address_translator.sv
// Top level of the CHS/LBA address translator.
// Translates CHS to LBA (cmd 0) or LBA to CHS (cmd 1) using the heads per cylinder
// (register 0, reset 16) and sectors per track (register 1, reset 63) geometry.
// One item is accepted per cycle while the queue is not full, and one result per item
// comes out in order, through two dividers pipelined one quotient bit per stage.
// Items queue in a small buffer while the result side stalls. The user must write
// configuration only when idle; the block itself does not enforce this.
module chs_lba_address_translator #(
   parameter int BLOCK_WIDTH = chs_pkg::BLOCK_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = chs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [31:0] req_cylinder_in,
   input  logic [7:0]  req_head_in,
   input  logic [7:0]  req_sector_in,
   input  logic [63:0] req_block_in,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_block_out,
   output logic [63:0] rsp_cylinder_out,
   output logic [7:0]  rsp_head_out,
   output logic [7:0]  rsp_sector_out,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import chs_pkg::*;

   localparam int EW = BLOCK_WIDTH + 52;

   chs_geom_type   geom_ff;
   logic           q_push, q_pop, q_full, q_empty;
   logic [EW-1:0]  q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.heads   <= HEADS_RESET;
         geom_ff.sectors <= SECTORS_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_HEADS) begin
            geom_ff.heads <= csr_wdata;
         end else if (csr_index == CSR_SECTORS) begin
            geom_ff.sectors <= csr_wdata;
         end
      end
   end

   assign full = q_full;

   chs_front #(.BLOCK_WIDTH(BLOCK_WIDTH)) u_front (
      .geom            (geom_ff),
      .req_push        (push),
      .req_cmd         (req_cmd),
      .req_cylinder_in (req_cylinder_in),
      .req_head_in     (req_head_in),
      .req_sector_in   (req_sector_in),
      .req_block_in    (req_block_in),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_wdata)
   );

   chs_fifo #(.DATA_WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   chs_back #(.BLOCK_WIDTH(BLOCK_WIDTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .geom             (geom_ff),
      .q_empty          (q_empty),
      .q_data           (q_rdata),
      .q_pop            (q_pop),
      .rsp_pop          (pop),
      .rsp_empty        (empty),
      .rsp_block_out    (rsp_block_out),
      .rsp_cylinder_out (rsp_cylinder_out),
      .rsp_head_out     (rsp_head_out),
      .rsp_sector_out   (rsp_sector_out),
      .rsp_status       (rsp_status)
   );

endmodule

### rtl/chs_front.sv
// Front end: takes request items and classifies geometry and range errors.
module chs_front #(
   parameter int BLOCK_WIDTH = chs_pkg::BLOCK_WIDTH_DEFAULT
) (
   input  chs_pkg::chs_geom_type geom,
   input  logic                  req_push,
   input  logic                  req_cmd,
   input  logic [31:0]           req_cylinder_in,
   input  logic [7:0]            req_head_in,
   input  logic [7:0]            req_sector_in,
   input  logic [63:0]           req_block_in,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [BLOCK_WIDTH+51:0] q_data
);
   import chs_pkg::*;

   logic [2:0] status;

   always_comb begin
      status = STATUS_OK;
      if (geom.heads == 8'd0) begin
         status = STATUS_ZERO_HEADS;
      end else if (geom.sectors == 8'd0) begin
         status = STATUS_ZERO_SECTORS;
      end else if (req_cmd == CMD_CHS_TO_LBA) begin
         if (req_sector_in == 8'd0) begin
            status = STATUS_ZERO_SECTOR;
         end else if (req_head_in > geom.heads) begin
            status = STATUS_HEAD_BIG;
         end else if (req_sector_in > geom.sectors) begin
            status = STATUS_SECTOR_BIG;
         end
      end
   end

   assign q_push = req_push & ~q_full;
   assign q_data = {req_cmd, status, req_cylinder_in, req_head_in, req_sector_in,
                    req_block_in[BLOCK_WIDTH-1:0]};

endmodule

### rtl/chs_fifo.sv
// Small item queue between the front end and the back end.
module chs_fifo #(
   parameter int DATA_WIDTH = 116,
   parameter int DEPTH      = chs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] wdata,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### rtl/chs_back.sv
// Back end: multiply path and two pipelined bit-serial dividers, plus result register.
module chs_back #(
   parameter int BLOCK_WIDTH = chs_pkg::BLOCK_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  chs_pkg::chs_geom_type   geom,
   input  logic                    q_empty,
   input  logic [BLOCK_WIDTH+51:0] q_data,
   output logic                    q_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic [63:0]             rsp_block_out,
   output logic [63:0]             rsp_cylinder_out,
   output logic [7:0]              rsp_head_out,
   output logic [7:0]              rsp_sector_out,
   output logic [2:0]              rsp_status
);
   import chs_pkg::*;

   localparam int W = BLOCK_WIDTH;
   localparam int L = 2 * W + 2;

   logic         advance;
   logic         valid_ff  [0:L-1];
   logic         cmd_ff    [0:L-1];
   logic [2:0]   status_ff [0:L-1];
   logic [W-1:0] work_ff   [0:L-1];
   logic [7:0]   rem1_ff   [0:L-1];
   logic [7:0]   rem2_ff   [0:L-1];

   logic [15:0]  p1_ff, p1_in;
   logic [16:0]  p2_ff, p2_in;
   logic [31:0]  cyl_ff;
   logic [47:0]  prod;
   logic [63:0]  lba_full;

   logic         q_cmd;
   logic [2:0]   q_status;
   logic [31:0]  q_cyl;
   logic [7:0]   q_hd;
   logic [7:0]   q_sec;
   logic [W-1:0] q_blk;

   logic         out_valid_ff;
   logic         out_cmd_ff;
   logic [2:0]   fin_status;
   logic [8:0]   fin_sector;

   assign {q_cmd, q_status, q_cyl, q_hd, q_sec, q_blk} = q_data;

   // hold the whole pipe while the result register is not taken
   assign advance   = ~out_valid_ff | rsp_pop;
   assign q_pop     = advance & ~q_empty;
   assign rsp_empty = ~out_valid_ff;

   assign p1_in = 16'(geom.heads) * 16'(geom.sectors);
   assign p2_in = 17'(16'(geom.sectors) * 16'(q_hd)) + 17'(q_sec) - 17'd1;

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff[0]    <= q_cmd;
         status_ff[0] <= q_status;
         work_ff[0]   <= q_blk;
         rem1_ff[0]   <= '0;
         rem2_ff[0]   <= '0;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         cyl_ff       <= q_cyl;
      end
   end

   assign prod     = 48'(p1_ff) * 48'(cyl_ff);
   assign lba_full = 64'(prod) + 64'(p2_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff[1]    <= cmd_ff[0];
         status_ff[1] <= status_ff[0];
         work_ff[1]   <= (cmd_ff[0] == CMD_LBA_TO_CHS) ? work_ff[0] : lba_full[W-1:0];
         rem1_ff[1]   <= rem1_ff[0];
         rem2_ff[1]   <= rem2_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
         valid_ff[1] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= ~q_empty;
         valid_ff[1] <= valid_ff[0];
      end
   end

   // stages 2..W+1 divide the block by sectors, W+2..2W+1 the quotient by heads
   for (genvar i = 2; i < L; i++) begin : g_div
      logic       first;
      logic [7:0] divisor;
      logic [7:0] rem_prev;
      logic [8:0] trial;
      logic       take;
      logic [7:0] rem_next;

      assign first    = (i <= W + 1);
      assign divisor  = first ? geom.sectors : geom.heads;
      assign rem_prev = first ? rem1_ff[i-1] : rem2_ff[i-1];
      assign trial    = {rem_prev, work_ff[i-1][W-1]};
      assign take     = (trial >= {1'b0, divisor});
      assign rem_next = take ? 8'(trial - {1'b0, divisor}) : trial[7:0];

      always_ff @(posedge clock) begin
         if (advance) begin
            cmd_ff[i]    <= cmd_ff[i-1];
            status_ff[i] <= status_ff[i-1];
            if (cmd_ff[i-1] == CMD_LBA_TO_CHS) begin
               work_ff[i] <= {work_ff[i-1][W-2:0], take};
               rem1_ff[i] <= first ? rem_next : rem1_ff[i-1];
               rem2_ff[i] <= first ? rem2_ff[i-1] : rem_next;
            end else begin
               work_ff[i] <= work_ff[i-1];
               rem1_ff[i] <= rem1_ff[i-1];
               rem2_ff[i] <= rem2_ff[i-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign fin_sector = 9'(rem1_ff[L-1]) + 9'd1;

   always_comb begin
      fin_status = status_ff[L-1];
      if (fin_status == STATUS_OK && cmd_ff[L-1] == CMD_LBA_TO_CHS) begin
         if (rem2_ff[L-1] > FIXED_HEAD_LIMIT) begin
            fin_status = STATUS_HEAD_BIG;
         end else if (fin_sector > FIXED_SECTOR_LIMIT) begin
            fin_status = STATUS_SECTOR_BIG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[L-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_cmd_ff       <= cmd_ff[L-1];
         rsp_status       <= fin_status;
         rsp_block_out    <= '0;
         rsp_cylinder_out <= '0;
         rsp_head_out     <= '0;
         rsp_sector_out   <= '0;
         if (fin_status == STATUS_OK) begin
            if (cmd_ff[L-1] == CMD_LBA_TO_CHS) begin
               rsp_cylinder_out <= 64'(work_ff[L-1]);
               rsp_head_out     <= rem2_ff[L-1];
               rsp_sector_out   <= fin_sector[7:0];
            end else begin
               rsp_block_out <= 64'(work_ff[L-1]);
            end
         end
      end
   end

`ifndef SYNTH
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_status != STATUS_OK) |->
         (rsp_block_out == '0 && rsp_cylinder_out == '0 &&
          rsp_head_out == '0 && rsp_sector_out == '0))
      else $error("error result carries nonzero payload");
   a_lba_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_cmd_ff == CMD_CHS_TO_LBA) |->
         (rsp_cylinder_out == '0 && rsp_head_out == '0 && rsp_sector_out == '0))
      else $error("CHS fields set on CHS to LBA result");
   a_chs_sector: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_cmd_ff == CMD_LBA_TO_CHS && rsp_status == STATUS_OK) |->
         (rsp_sector_out != 8'd0 && rsp_block_out == '0))
      else $error("bad LBA to CHS result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(rsp_status)))
      else $error("stalled result changed");
`endif

endmodule
